// ----- hdl/u8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the six-byte UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  // Upper bound on the reported character total.
  localparam longint unsigned COUNT_MAX = 64'd65535;
  localparam longint unsigned TOTAL_LIMIT = (COUNT_MAX > 64'd65535) ? 64'd65535 : COUNT_MAX;

  localparam int CP_W    = 31;
  localparam int TOTAL_W = 16;
  localparam int LEFT_W  = 3;

  // Lead byte ranges
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;
  localparam logic [7:0] LEAD5_MIN = 8'hF8;
  localparam logic [7:0] LEAD5_MAX = 8'hFB;
  localparam logic [7:0] LEAD6_MIN = 8'hFC;
  localparam logic [7:0] LEAD6_MAX = 8'hFD;
  localparam logic [7:0] CONT_BITS = 8'h3F;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  localparam logic       MODE_DATA = 1'b0;
  localparam logic       MODE_END  = 1'b1;

  typedef enum logic [1:0] {
    KIND_CP  = 2'd0,
    KIND_END = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [CP_W-1:0]     code_point;
    logic [TOTAL_W-1:0]  char_total;
  } result_t;

endpackage

// ----- hdl/utf8_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Six-byte UTF-8 stream decoder producing 31-bit code points.
// ----------------------------------------------------------------------------
// Takes one byte word (or an end-of-string word) per clock while the output
// is not stalled and returns at most one result word for it: an input
// register feeds a combinational decode step whose result lands in an output
// register. The rate is set only by the output register's handshake, which
// also stalls the input while a result waits. Lead and continuation bytes
// yield no result until the character is complete. Errors (bad lead, bad
// continuation, end mid-sequence) report once, then bytes are dropped
// silently until the next end word, which resets the decoder without a
// result. A clean end reports the number of characters seen plus one,
// saturating at 65535. Overlong forms pass.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [30:0] out_code_point,
  output logic [15:0] out_char_total
);

  // stage 1 word
  logic       s1_valid;
  logic       s1_mode;
  logic [7:0] s1_byte;

  // decode step handshake
  logic              advance;
  logic              fire;
  logic              emit;
  u8sd_pkg::result_t step_result;
  u8sd_pkg::result_t out_result;

  u8sd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1_mode      (s1_mode),
    .s1_byte      (s1_byte)
  );

  // state lives here and only moves when the stage 1 word is consumed
  u8sd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .mode      (s1_mode),
    .data_byte (s1_byte),
    .emit      (emit),
    .result    (step_result)
  );

  u8sd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .emit       (emit),
    .result     (step_result),
    .advance    (advance),
    .fire       (fire),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign out_kind       = out_result.kind;
  assign out_code_point = out_result.code_point;
  assign out_char_total = out_result.char_total;

`ifndef SYNTH
  // input stalls only when a word is parked in stage 1
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid)
    else $error("input stalled with empty stage 1");

  // a blocked output must keep the stage 1 word in place
  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && s1_valid) |=> s1_valid)
    else $error("stage 1 word lost under output stall");

  // code point results carry no total; end results carry a nonzero total
  a_cp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == u8sd_pkg::KIND_CP) |-> (out_char_total == '0))
    else $error("code point result with nonzero total");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == u8sd_pkg::KIND_END) |->
      (out_code_point == '0 && out_char_total != '0))
    else $error("malformed end result");
`endif

endmodule

// ----- hdl/u8sd_in_stage.sv -----
// ----------------------------------------------------------------------------
// u8sd_in_stage
// Input register: holds one word until the decode step can consume it.
// ----------------------------------------------------------------------------
module u8sd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic       s1_mode,
  output logic [7:0] s1_byte
);

  logic       valid_r, valid_nxt;
  logic       mode_r;
  logic [7:0] byte_r;
  logic       load;

  assign in_stall  = valid_r && !advance;
  assign load      = !in_stall;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      mode_r <= in_mode;
      byte_r <= in_data_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_mode  = mode_r;
  assign s1_byte  = byte_r;

endmodule

// ----- hdl/u8sd_step.sv -----
// ----------------------------------------------------------------------------
// u8sd_step
// Decoder state and the per-word decode step.
// ----------------------------------------------------------------------------
module u8sd_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              mode,
  input  logic [7:0]        data_byte,
  output logic              emit,
  output u8sd_pkg::result_t result
);

  logic [u8sd_pkg::LEFT_W-1:0]  left_r, left_nxt;
  logic [u8sd_pkg::CP_W-1:0]    part_r, part_nxt;
  logic [u8sd_pkg::TOTAL_W-1:0] cnt_r, cnt_nxt;
  logic                         disc_r, disc_nxt;

  logic [u8sd_pkg::CP_W-1:0]    part_shift;
  logic [u8sd_pkg::LEFT_W-1:0]  left_dec;
  logic [u8sd_pkg::TOTAL_W:0]   cnt_plus;
  logic                         cnt_can_inc;

  assign part_shift  = {part_r[u8sd_pkg::CP_W-7:0], data_byte[5:0] & u8sd_pkg::CONT_BITS[5:0]};
  assign left_dec    = left_r - u8sd_pkg::LEFT_W'(1);
  assign cnt_plus    = {1'b0, cnt_r} + (u8sd_pkg::TOTAL_W+1)'(1);
  assign cnt_can_inc = cnt_plus < (u8sd_pkg::TOTAL_W+1)'(u8sd_pkg::TOTAL_LIMIT);

  always_comb begin
    left_nxt = left_r;
    part_nxt = part_r;
    cnt_nxt  = cnt_r;
    disc_nxt = disc_r;
    emit     = 1'b0;
    result   = '{kind: u8sd_pkg::KIND_CP, code_point: '0, char_total: '0};

    if (mode == u8sd_pkg::MODE_END) begin
      left_nxt = '0;
      part_nxt = '0;
      cnt_nxt  = '0;
      disc_nxt = 1'b0;
      if (!disc_r) begin
        emit = 1'b1;
        if (left_r != '0) begin
          result.kind = u8sd_pkg::KIND_ERR;
        end else begin
          result.kind       = u8sd_pkg::KIND_END;
          result.char_total = cnt_plus[u8sd_pkg::TOTAL_W-1:0];
        end
      end
    end else if (disc_r) begin
      // dropping bytes until end of string
    end else if (left_r != '0) begin
      if (data_byte[7:6] != u8sd_pkg::CONT_TAG) begin
        left_nxt    = '0;
        part_nxt    = '0;
        disc_nxt    = 1'b1;
        emit        = 1'b1;
        result.kind = u8sd_pkg::KIND_ERR;
      end else begin
        left_nxt = left_dec;
        part_nxt = part_shift;
        if (left_dec == '0) begin
          part_nxt          = '0;
          emit              = 1'b1;
          result.code_point = part_shift;
          if (cnt_can_inc) cnt_nxt = cnt_plus[u8sd_pkg::TOTAL_W-1:0];
        end
      end
    end else if (data_byte <= u8sd_pkg::ASCII_MAX) begin
      emit              = 1'b1;
      result.code_point = u8sd_pkg::CP_W'(data_byte);
      if (cnt_can_inc) cnt_nxt = cnt_plus[u8sd_pkg::TOTAL_W-1:0];
    end else if (data_byte >= u8sd_pkg::LEAD2_MIN && data_byte <= u8sd_pkg::LEAD2_MAX) begin
      part_nxt = u8sd_pkg::CP_W'(data_byte[4:0]);
      left_nxt = u8sd_pkg::LEFT_W'(1);
    end else if (data_byte >= u8sd_pkg::LEAD3_MIN && data_byte <= u8sd_pkg::LEAD3_MAX) begin
      part_nxt = u8sd_pkg::CP_W'(data_byte[3:0]);
      left_nxt = u8sd_pkg::LEFT_W'(2);
    end else if (data_byte >= u8sd_pkg::LEAD4_MIN && data_byte <= u8sd_pkg::LEAD4_MAX) begin
      part_nxt = u8sd_pkg::CP_W'(data_byte[2:0]);
      left_nxt = u8sd_pkg::LEFT_W'(3);
    end else if (data_byte >= u8sd_pkg::LEAD5_MIN && data_byte <= u8sd_pkg::LEAD5_MAX) begin
      part_nxt = u8sd_pkg::CP_W'(data_byte[1:0]);
      left_nxt = u8sd_pkg::LEFT_W'(4);
    end else if (data_byte >= u8sd_pkg::LEAD6_MIN && data_byte <= u8sd_pkg::LEAD6_MAX) begin
      part_nxt = u8sd_pkg::CP_W'(data_byte[0]);
      left_nxt = u8sd_pkg::LEFT_W'(5);
    end else begin
      // stray continuation byte or 0xFE/0xFF
      disc_nxt    = 1'b1;
      emit        = 1'b1;
      result.kind = u8sd_pkg::KIND_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      part_r <= '0;
      cnt_r  <= '0;
      disc_r <= 1'b0;
    end else if (fire) begin
      left_r <= left_nxt;
      part_r <= part_nxt;
      cnt_r  <= cnt_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

// ----- hdl/u8sd_out_stage.sv -----
// ----------------------------------------------------------------------------
// u8sd_out_stage
// Result register on the output channel; frees the decode step whenever
// it is empty or its word is being taken.
// ----------------------------------------------------------------------------
module u8sd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  logic              emit,
  input  u8sd_pkg::result_t result,
  output logic              advance,
  output logic              fire,
  input  logic              out_stall,
  output logic              out_valid,
  output u8sd_pkg::result_t out_result
);

  logic              valid_r, valid_nxt;
  u8sd_pkg::result_t result_r;

  assign advance   = !valid_r || !out_stall;
  assign fire      = s1_valid && advance;
  assign valid_nxt = advance ? (fire && emit) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ----- tb/u8sd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sd_tb_pkg
// Scoreboard for the six-byte UTF-8 stream decoder: predicts the result word,
// if any, of every accepted byte or end word and checks returned words in order.
// ----------------------------------------------------------------------------
package u8sd_tb_pkg;

  import u8sd_pkg::*;

  class utf8_decode_scoreboard;

    // decoder state as the predictor sees it
    logic [LEFT_W-1:0]  cont_pending;
    logic [CP_W-1:0]    value_acc;
    logic [TOTAL_W-1:0] chars_seen;
    bit                 dropping;

    result_t            expected_results[$];
    int unsigned        failures;
    int unsigned        seen_kind[3];

    function new();
      clear_string();
      failures = 0;
    endfunction

    function void clear_string();
      cont_pending = '0;
      value_acc    = '0;
      chars_seen   = '0;
      dropping     = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Count saturates one below the ceiling so that count + 1 never wraps.
    function void count_char();
      if (longint'(chars_seen) + 1 < TOTAL_LIMIT)
        chars_seen++;
    endfunction

    // Takes one accepted word; returns 1 unless the word was silently dropped.
    function bit note_word(logic mode, logic [7:0] b);
      result_t r;
      bit      has_result;
      bit      used;
      r          = '0;
      has_result = 1'b0;
      used       = (mode == MODE_END) || !dropping;
      if (mode == MODE_END) begin
        if (dropping) begin
          clear_string();
        end else if (cont_pending != 0) begin
          r.kind     = KIND_ERR;
          has_result = 1'b1;
          clear_string();
        end else begin
          r.kind       = KIND_END;
          r.char_total = chars_seen + 1'b1;
          has_result   = 1'b1;
          clear_string();
        end
      end else if (!dropping) begin
        if (cont_pending != 0) begin
          if (b[7:6] != CONT_TAG) begin
            cont_pending = '0;
            value_acc    = '0;
            dropping     = 1'b1;
            r.kind       = KIND_ERR;
            has_result   = 1'b1;
          end else begin
            value_acc = {value_acc[CP_W-7:0], b[5:0]};
            cont_pending--;
            if (cont_pending == 0) begin
              r.kind       = KIND_CP;
              r.code_point = value_acc;
              value_acc    = '0;
              has_result   = 1'b1;
              count_char();
            end
          end
        end else if (b <= ASCII_MAX) begin
          r.kind       = KIND_CP;
          r.code_point = CP_W'(b);
          has_result   = 1'b1;
          count_char();
        // within each lead range, clearing the range's low bound leaves the payload
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          value_acc    = CP_W'(b & ~LEAD2_MIN);
          cont_pending = 3'd1;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          value_acc    = CP_W'(b & ~LEAD3_MIN);
          cont_pending = 3'd2;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          value_acc    = CP_W'(b & ~LEAD4_MIN);
          cont_pending = 3'd3;
        end else if (b >= LEAD5_MIN && b <= LEAD5_MAX) begin
          value_acc    = CP_W'(b & ~LEAD5_MIN);
          cont_pending = 3'd4;
        end else if (b >= LEAD6_MIN && b <= LEAD6_MAX) begin
          value_acc    = CP_W'(b & ~LEAD6_MIN);
          cont_pending = 3'd5;
        end else begin
          dropping   = 1'b1;
          r.kind     = KIND_ERR;
          has_result = 1'b1;
        end
      end
      if (has_result)
        expected_results.push_back(r);
      return used;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      failures++;
    endtask

    task check_result(logic [1:0] kind, logic [CP_W-1:0] cp, logic [TOTAL_W-1:0] total);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d cp %h total %0d",
                                  kind, cp, total));
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (cp !== want.code_point)
          report_mismatch($sformatf("code point %h, want %h", cp, want.code_point));
        if (total !== want.char_total)
          report_mismatch($sformatf("char total %0d, want %0d", total, want.char_total));
        if (want.kind <= KIND_ERR)
          seen_kind[want.kind]++;
      end
    endtask

  endclass

endpackage

// ----- tb/tb_utf8_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit
// Self-checking bench for the six-byte UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// Drives byte and end words through the valid/stall input, predicts every
// result word in a scoreboard and checks returned words in order. Directed
// strings hit the code point extremes and each error path; random strings follow,
// mostly well formed, with bad leads, bad continuations, truncated sequences
// and noise mixed in. Both sides idle at random, except in one stretch without
// idling.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import u8sd_pkg::*;
  import u8sd_tb_pkg::*;

  localparam int unsigned HOLD_LEN    = 200;    // receiver hold-off, cycles
  localparam int unsigned QUIET_LIMIT = 2000;   // cycles with no word moving

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_mode      = MODE_DATA;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [30:0] out_code_point;
  logic [15:0] out_char_total;

  utf8_decode_scoreboard sb;

  int unsigned idle_pct    = 27;  // idle / stall chance per cycle, both sides
  int unsigned n_items     = 0;   // words not silently dropped by the decoder
  int unsigned hold_asks   = 0;   // bumped by the sender to request a hold-off
  int unsigned hold_served = 0;

  always #6 clk = ~clk;

  utf8_stream_decoder_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_code_point (out_code_point),
    .out_char_total (out_char_total)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one word, idling first at random, and hold it until accepted.
  // Everything is sampled right after the edge, i.e. the values the DUT saw.
  task automatic send_word(logic mode, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    if (sb.note_word(mode, b))
      n_items++;
  endtask

  // First n_bytes of the len-byte encoding of cp (len 1 is plain ASCII).
  task automatic send_char_bytes(int unsigned cp, int unsigned len, int unsigned n_bytes);
    logic [7:0] b;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if (len == 1)
        b = 8'(cp) & ASCII_MAX;
      else if (i == 0)
        b = 8'(8'hFF << (8 - len)) | 8'((cp >> (6 * (len - 1))) & (32'h7F >> len));
      else
        b = {CONT_TAG, 6'(cp >> (6 * (len - 1 - i)))};
      send_word(MODE_DATA, b);
    end
  endtask

  // Any value that fits a len-byte form; a quarter are small (overlong forms).
  function automatic int unsigned rand_code_point(int unsigned len);
    int unsigned bits;
    bits = (len == 1) ? 7 : 5 * len + 1;
    if ($urandom_range(3) == 0)
      return $urandom_range(0, 127);
    return $urandom & ((32'h1 << bits) - 1);
  endfunction

  // One string: mostly clean characters, some broken, then an end word.
  task automatic send_string(int unsigned n_chars);
    int unsigned len;
    int unsigned cp;
    int unsigned x;
    logic [7:0]  b;
    bit          cut;
    cut = 1'b0;
    for (int unsigned i = 0; i < n_chars && !cut; i++) begin
      len = $urandom_range(1, 6);
      cp  = rand_code_point(len);
      if ($urandom_range(99) < 85) begin
        send_char_bytes(cp, len, len);
      end else begin
        len = $urandom_range(2, 6);
        cp  = rand_code_point(len);
        case ($urandom_range(3))
          0: begin
            // lead byte that starts nothing: a bare continuation or FE/FF
            x = $urandom_range(0, 65);
            b = (x < 64) ? 8'(8'h80 + x) : 8'(8'hFE + x - 64);
            send_word(MODE_DATA, b);
          end
          1: begin
            // sequence broken by a byte that is not 10xxxxxx
            send_char_bytes(cp, len, $urandom_range(1, len - 1));
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == CONT_TAG)
              b[6] = 1'b1;
            send_word(MODE_DATA, b);
          end
          2: begin
            // string ends in the middle of a sequence
            send_char_bytes(cp, len, $urandom_range(1, len - 1));
            send_word(MODE_END, 8'($urandom));
            cut = 1'b1;
          end
          default: begin
            send_word(MODE_DATA, 8'($urandom));
          end
        endcase
      end
    end
    if (!cut)
      send_word(MODE_END, 8'($urandom));
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: checks each accepted word, stalls at random, and runs a
  // long hold-off whenever the sender asks for one.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_kind, out_code_point, out_char_total);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_cnt    = HOLD_LEN - 1;
        out_stall   <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // Watchdog: a correct run never goes this long without moving a word.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ASCII extremes (zero byte included), overlong two-byte zero,
    // largest six-byte value, end word carrying junk data -> total 5
    send_char_bytes(32'h00, 1, 1);
    send_char_bytes(32'h7F, 1, 1);
    send_char_bytes(32'h00, 2, 2);
    send_char_bytes(32'h7FFF_FFFF, 6, 6);
    send_word(MODE_END, 8'hFF);
    // empty string -> total 1
    send_word(MODE_END, 8'h00);
    // bad lead, a dropped byte, then a silent end
    send_word(MODE_DATA, 8'h80);
    send_word(MODE_DATA, 8'h41);
    send_word(MODE_END, 8'h00);
    // FE is a bad lead; FF after it is dropped
    send_word(MODE_DATA, 8'hFE);
    send_word(MODE_DATA, 8'hFF);
    send_word(MODE_END, 8'h00);
    // bad continuation
    send_word(MODE_DATA, 8'hE2);
    send_word(MODE_DATA, 8'h41);
    send_word(MODE_END, 8'h00);
    // end in the middle of a five-byte sequence
    send_word(MODE_DATA, 8'hF8);
    send_word(MODE_DATA, 8'h80);
    send_word(MODE_END, 8'h00);
    drain();

    // random strings with idling on both sides
    while (n_items < 300)
      send_string($urandom_range(0, 12));

    // a stretch with no idling at all
    idle_pct = 0;
    while (n_items < 450)
      send_string($urandom_range(0, 12));
    idle_pct = 27;

    // receiver holds off while the sender keeps offering; the DUT backs up
    hold_asks++;
    send_string(24);
    // sender pauses until everything is back
    drain();

    while (n_items < 650)
      send_string($urandom_range(0, 12));

    drain();
    repeat (8) @(posedge clk);

    $display("Run: %0d decoded words over directed and random strings, %0d-cycle hold-off.",
             n_items, HOLD_LEN);
    $display("Checked %0d code points, %0d string totals, %0d error words; %0d mismatches.",
             sb.seen_kind[KIND_CP], sb.seen_kind[KIND_END], sb.seen_kind[KIND_ERR],
             sb.failures);
    if (sb.failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- utf8_stream_decoder_unit.f -----
hdl/u8sd_pkg.sv
hdl/u8sd_in_stage.sv
hdl/u8sd_step.sv
hdl/u8sd_out_stage.sv
hdl/utf8_stream_decoder_unit.sv
tb/u8sd_tb_pkg.sv
tb/tb_utf8_stream_decoder_unit.sv
